FILE: rtl/core/ias_pkg.sv
// Shared types, register indexes and reset values for the intrusion alarm sequencer.
package ias_pkg;

    // Phase codes as they appear on the result word.
    typedef enum logic [2:0] {
        PH_STARTUP  = 3'd0,
        PH_ARMED    = 3'd1,
        PH_PREALERT = 3'd2,
        PH_SIREN    = 3'd3,
        PH_DONE     = 3'd4,
        PH_WAIT     = 3'd5
    } phase_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STARTUP  = 3'd0;
    localparam logic [2:0] CFG_PREALERT = 3'd1;
    localparam logic [2:0] CFG_SIREN    = 3'd2;
    localparam logic [2:0] CFG_REARM    = 3'd3;
    localparam logic [2:0] CFG_LIMIT    = 3'd4;

    // Register values after reset.
    localparam logic [7:0] RESET_STARTUP  = 8'd30;
    localparam logic [7:0] RESET_PREALERT = 8'd30;
    localparam logic [7:0] RESET_SIREN    = 8'd30;
    localparam logic [7:0] RESET_REARM    = 8'd60;
    localparam logic [2:0] RESET_LIMIT    = 3'd5;

    // Sequencer state carried from one event to the next.
    typedef struct packed {
        phase_t     phase;
        logic [7:0] tick_count;
        logic       siren;
        logic       led;
        logic [2:0] alerts_done;
    } ias_state_t;

    // Programmed phase lengths and alert limit.
    typedef struct packed {
        logic [7:0] startup_ticks;
        logic [7:0] prealert_ticks;
        logic [7:0] siren_ticks;
        logic [7:0] rearm_ticks;
        logic [2:0] alert_limit;
    } ias_cfg_t;

endpackage

FILE: rtl/core/ias_step.sv
// Next-state logic of the alarm phase machine for one tick or trigger event.
module ias_step (
    input  ias_pkg::ias_state_t cur_i,
    input  ias_pkg::ias_cfg_t   cfg_i,
    input  logic                mode_i,
    input  logic                repeat_i,
    output ias_pkg::ias_state_t nxt_o
);
    import ias_pkg::*;

    logic [7:0] cnt_inc;

    // Tick counter after this event, wrapping from 255 to 0.
    assign cnt_inc = cur_i.tick_count + 8'd1;

    // A trigger only matters while armed; a tick advances the startup, pre-alert, siren and wait phases.
    always_comb begin
        nxt_o = cur_i;
        if (mode_i) begin
            if (cur_i.phase == PH_ARMED) begin
                nxt_o.phase = PH_PREALERT;
            end
        end else begin
            case (cur_i.phase)
                PH_STARTUP: begin
                    nxt_o.tick_count = cnt_inc;
                    if (cnt_inc == cfg_i.startup_ticks) begin
                        nxt_o.siren      = 1'b0;
                        nxt_o.tick_count = 8'd0;
                        nxt_o.phase      = PH_ARMED;
                    end else begin
                        nxt_o.siren = ~cur_i.siren;
                    end
                end
                PH_PREALERT: begin
                    nxt_o.led        = 1'b1;
                    nxt_o.tick_count = cnt_inc;
                    if (cnt_inc == cfg_i.prealert_ticks) begin
                        nxt_o.siren      = 1'b1;
                        nxt_o.tick_count = 8'd0;
                        nxt_o.phase      = PH_SIREN;
                    end else begin
                        nxt_o.siren = ~cur_i.siren;
                    end
                end
                PH_SIREN: begin
                    nxt_o.tick_count = cnt_inc;
                    if (cnt_inc == cfg_i.siren_ticks) begin
                        // Repeat only while the alert count is below its limit.
                        if (repeat_i && (cur_i.alerts_done < cfg_i.alert_limit)) begin
                            nxt_o.alerts_done = cur_i.alerts_done + 3'd1;
                            nxt_o.phase       = PH_WAIT;
                        end else begin
                            nxt_o.phase = PH_DONE;
                        end
                        nxt_o.siren      = 1'b0;
                        nxt_o.tick_count = 8'd0;
                    end
                end
                PH_WAIT: begin
                    nxt_o.tick_count = cnt_inc;
                    if (cnt_inc == cfg_i.rearm_ticks) begin
                        nxt_o.siren      = 1'b0;
                        nxt_o.tick_count = 8'd0;
                        nxt_o.phase      = PH_ARMED;
                    end
                end
                default: begin
                    nxt_o = cur_i;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/intrusion_alarm_sequencer.sv
// Top level of the intrusion alarm sequencer: event channel, result channel and registers.
//
// Usage: each word on the s_ channel is one event. s_tuser selects its kind
// (0 timer tick, 1 trigger) and s_tdata[0] carries the repeat jumper level.
// Every event yields exactly one result word on the m_ channel with the siren
// level, the indicator level and the phase after that event.
// Each accepted event is held in the input register; its phase update is then
// stored in the result register, from which the result word is offered.
// Throughput: one event per cycle while the receiver keeps taking results; the
// phase machine state is a single register updated by one increment, compare
// and select per event.
// While the receiver stalls, the held result stays on m_tdata and one more
// event is taken into the input register; s_tready then drops until the
// result word is taken.
// Registers are written on the cfg_ port, which is always ready; write them
// only while no event is in flight.
// Reset (aresetn low, synchronous) empties both registers stages, loads the
// register defaults and puts the machine in the startup phase, siren and
// indicator off, alert count zero.
module intrusion_alarm_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    // Event channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] repeat_enable, [7:1] zero
    input  logic       s_tuser,   // [0] mode
    // Result channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] siren, [1] indicator, [4:2] phase, [7:5] zero
    // Register write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import ias_pkg::*;

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic       in_repeat_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    ias_state_t state_reg;
    ias_state_t state_next;
    ias_cfg_t   cfg_reg;
    logic       advance;
    logic       fire;

    // Handshake: the input stage moves on when the result register is free.
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_mode_reg   <= s_tuser;
            in_repeat_reg <= s_tdata[0];
        end
    end

    // Phase update for the event in the input register.
    ias_step u_step (
        .cur_i    (state_reg),
        .cfg_i    (cfg_reg),
        .mode_i   (in_mode_reg),
        .repeat_i (in_repeat_reg),
        .nxt_o    (state_next)
    );

    // Result valid stays up while stalled, or is refilled as it is taken.
    always_comb begin
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Machine state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= PH_STARTUP;
            state_reg.tick_count  <= 8'd0;
            state_reg.siren       <= 1'b0;
            state_reg.led         <= 1'b0;
            state_reg.alerts_done <= 3'd0;
            out_valid_reg         <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
        if (fire) begin
            out_data_reg <= {3'b000, state_next.phase, state_next.led, state_next.siren};
        end
    end

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.startup_ticks  <= RESET_STARTUP;
            cfg_reg.prealert_ticks <= RESET_PREALERT;
            cfg_reg.siren_ticks    <= RESET_SIREN;
            cfg_reg.rearm_ticks    <= RESET_REARM;
            cfg_reg.alert_limit    <= RESET_LIMIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STARTUP:  cfg_reg.startup_ticks  <= cfg_data;
                CFG_PREALERT: cfg_reg.prealert_ticks <= cfg_data;
                CFG_SIREN:    cfg_reg.siren_ticks    <= cfg_data;
                CFG_REARM:    cfg_reg.rearm_ticks    <= cfg_data;
                CFG_LIMIT:    cfg_reg.alert_limit    <= cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // The indicator never clears once lit.
    a_led_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.led |=> state_reg.led)
        else $error("indicator cleared after being set");

    // Armed and done phases always report a silent siren.
    a_quiet_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[4:2] == PH_ARMED) || (m_tdata[4:2] == PH_DONE))
        |-> !m_tdata[0])
        else $error("siren on in armed or done phase");

    // The steady siren phase is only reached through the pre-alert, which lights the LED.
    a_siren_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:2] == PH_SIREN) |-> m_tdata[1])
        else $error("siren phase without indicator");

endmodule

FILE: tb/alarm_sequence_checker.sv
// Checker for the intrusion alarm sequencer: follows the channels, predicts each result word and compares.
module alarm_sequence_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] repeat_enable, [7:1] zero
    input  logic       s_tuser,   // [0] mode
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] siren, [1] indicator, [4:2] phase, [7:5] zero
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         outstanding,
    output int         words_checked
);
    import ias_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result word.
    typedef struct {
        logic   siren;
        logic   indicator;
        phase_t phase;
    } alarm_word_t;

    ias_state_t  alarm;
    ias_cfg_t    setting;
    alarm_word_t expected_alarm_words[$];
    int          failures = 0;
    int          checked = 0;

    // Moves the predicted sequencer on by one event and returns the word it should show.
    function automatic alarm_word_t advance_alarm(input logic trigger, input logic repeat_on);
        alarm_word_t word;
        if (trigger) begin
            // Only an armed sequencer reacts to the trigger pin.
            if (alarm.phase == PH_ARMED) begin
                alarm.phase = PH_PREALERT;
            end
        end else begin
            case (alarm.phase)
                PH_STARTUP: begin
                    alarm.tick_count = alarm.tick_count + 8'd1;
                    if (alarm.tick_count == setting.startup_ticks) begin
                        alarm.siren      = 1'b0;
                        alarm.tick_count = 8'd0;
                        alarm.phase      = PH_ARMED;
                    end else begin
                        alarm.siren = ~alarm.siren;
                    end
                end
                PH_PREALERT: begin
                    alarm.led        = 1'b1;
                    alarm.tick_count = alarm.tick_count + 8'd1;
                    if (alarm.tick_count == setting.prealert_ticks) begin
                        alarm.siren      = 1'b1;
                        alarm.tick_count = 8'd0;
                        alarm.phase      = PH_SIREN;
                    end else begin
                        alarm.siren = ~alarm.siren;
                    end
                end
                PH_SIREN: begin
                    alarm.tick_count = alarm.tick_count + 8'd1;
                    if (alarm.tick_count == setting.siren_ticks) begin
                        // Another round only with the jumper fitted and the limit not yet reached.
                        if (repeat_on && alarm.alerts_done < setting.alert_limit) begin
                            alarm.alerts_done = alarm.alerts_done + 3'd1;
                            alarm.phase       = PH_WAIT;
                        end else begin
                            alarm.phase = PH_DONE;
                        end
                        alarm.siren      = 1'b0;
                        alarm.tick_count = 8'd0;
                    end
                end
                PH_WAIT: begin
                    alarm.tick_count = alarm.tick_count + 8'd1;
                    if (alarm.tick_count == setting.rearm_ticks) begin
                        alarm.siren      = 1'b0;
                        alarm.tick_count = 8'd0;
                        alarm.phase      = PH_ARMED;
                    end
                end
                default: begin
                    // Armed and done sequencers ignore ticks.
                end
            endcase
        end
        word.siren     = alarm.siren;
        word.indicator = alarm.led;
        word.phase     = alarm.phase;
        return word;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        failures++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // All three channels are sampled at the clock edge, before the block updates.
    always @(posedge aclk) begin
        alarm_word_t want;
        if (!aresetn) begin
            alarm                  = '0;
            alarm.phase            = PH_STARTUP;
            setting.startup_ticks  = RESET_STARTUP;
            setting.prealert_ticks = RESET_PREALERT;
            setting.siren_ticks    = RESET_SIREN;
            setting.rearm_ticks    = RESET_REARM;
            setting.alert_limit    = RESET_LIMIT;
            expected_alarm_words.delete();
        end else begin
            // Result words are matched against the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (expected_alarm_words.size() == 0) begin
                    failures++;
                    $display("%0t: result word 0x%02h arrived with nothing expected",
                             $time, m_tdata);
                end else begin
                    want = expected_alarm_words.pop_front();
                    checked++;
                    if (m_tdata[0] !== want.siren) begin
                        report_mismatch("siren", 8'(want.siren), 8'(m_tdata[0]));
                    end
                    if (m_tdata[1] !== want.indicator) begin
                        report_mismatch("indicator", 8'(want.indicator), 8'(m_tdata[1]));
                    end
                    if (m_tdata[4:2] !== want.phase) begin
                        report_mismatch("phase", 8'(want.phase), 8'(m_tdata[4:2]));
                    end
                end
            end

            // Register writes; unknown indexes are dropped.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STARTUP:  setting.startup_ticks  = cfg_data;
                    CFG_PREALERT: setting.prealert_ticks = cfg_data;
                    CFG_SIREN:    setting.siren_ticks    = cfg_data;
                    CFG_REARM:    setting.rearm_ticks    = cfg_data;
                    CFG_LIMIT:    setting.alert_limit    = cfg_data[2:0];
                    default: begin
                    end
                endcase
            end

            // Every accepted event yields exactly one result word.
            if (s_tvalid && s_tready) begin
                expected_alarm_words.push_back(advance_alarm(s_tuser, s_tdata[0]));
            end
        end
        outstanding   <= expected_alarm_words.size();
        fail_count    <= failures;
        words_checked <= checked;
    end

endmodule

FILE: tb/intrusion_alarm_sequencer_test.sv
// Top of the intrusion alarm sequencer testbench: clock, reset, event stimulus and verdict.
module intrusion_alarm_sequencer_test;
    import ias_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Event kinds carried on s_tuser.
    localparam logic EV_TICK    = 1'b0;
    localparam logic EV_TRIGGER = 1'b1;
    // An index the block does not decode.
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;

    typedef struct {
        logic [2:0] index;
        logic [7:0] value;
    } reg_write_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count;
    int         outstanding;
    int         words_checked;

    reg_write_t pending_writes[$];
    int         events_sent = 0;
    int         writes_done = 0;
    int         burst_left = 0;
    int         gapless_items = 0;
    int         hold_asked = 0;
    int         holds_served = 0;
    int         quiet_cycles = 0;
    int         alerts_used = 0;

    intrusion_alarm_sequencer dut (.*);
    alarm_sequence_checker monitor (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offers one event word and returns once it is taken; gaps fall between bursts.
    task automatic send_event(input logic kind, input logic repeat_on);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, repeat_on};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
        if (gapless_items > 0) begin
            gapless_items--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // A run of ticks with stray triggers mixed in. The tick numbered repeat_at carries
    // the jumper fitted, so that a siren phase ending there goes on to wait.
    task automatic send_ticks(input int count, input int repeat_at);
        for (int i = 1; i <= count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_event(EV_TRIGGER, 1'($urandom_range(0, 1)));
            end
            send_event(EV_TICK, (i == repeat_at) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
    endtask

    // Drains the queued register writes, keeping valid high between them.
    task automatic flush_register_writes();
        reg_write_t w;
        while (pending_writes.size() > 0) begin
            w = pending_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.value;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            writes_done++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic program_alarm(input int startup, input int pre, input int sir,
                                 input int rea, input logic [7:0] limit_raw);
        pending_writes.push_back('{CFG_STARTUP, 8'(startup)});
        pending_writes.push_back('{CFG_PREALERT, 8'(pre)});
        pending_writes.push_back('{CFG_SIREN, 8'(sir)});
        pending_writes.push_back('{CFG_REARM, 8'(rea)});
        pending_writes.push_back('{CFG_LIMIT, limit_raw});
        flush_register_writes();
    endtask

    // Stops offering and waits until every predicted word has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One full alert round from armed: trigger, pre-alert, siren, then wait or latch.
    task automatic run_alert_cycle(input int pre, input int sir, input int rea, input bit latch);
        int idle_ticks;
        idle_ticks = $urandom_range(0, 3);
        repeat (idle_ticks) send_event(EV_TICK, 1'($urandom_range(0, 1)));
        send_event(EV_TRIGGER, 1'($urandom_range(0, 1)));
        send_ticks(pre + sir, latch ? 0 : pre + sir);
        send_ticks(rea, 0);
    endtask

    // Result side: stall patterns in spans, plus a long hold when asked for.
    initial begin : result_sink
        int span;
        int style;
        m_tready = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 80);
            while (span > 0) begin
                if (hold_asked != holds_served) begin
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    holds_served++;
                end
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge aclk);
                span--;
            end
        end
    end

    // Watchdog: too long without any word moving on any channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out after %0d quiet cycles with %0d words outstanding.",
                     quiet_cycles, outstanding);
            $display("intrusion_alarm_sequencer_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int pre;
        int sir;
        int rea;
        int limit;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = EV_TICK;
        cfg_valid = 1'b0;
        cfg_index = CFG_STARTUP;
        cfg_data  = 8'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short phases for the directed walk; the limit write has spare upper bits set.
        pending_writes.push_back('{CFG_UNUSED, 8'h5A});
        program_alarm(3, 2, 1, 2, 8'hFF);

        // Directed walk through every phase with a stray trigger in each.
        send_event(EV_TRIGGER, 1'b1);   // ignored during startup
        send_event(EV_TICK, 1'b0);
        send_event(EV_TICK, 1'b1);
        send_event(EV_TICK, 1'b0);      // startup count reached, armed
        send_event(EV_TICK, 1'b1);      // ignored while armed
        send_event(EV_TRIGGER, 1'b0);   // pre-alert starts
        send_event(EV_TRIGGER, 1'b1);   // ignored during pre-alert
        send_event(EV_TICK, 1'b0);
        send_event(EV_TICK, 1'b1);      // steady siren
        send_event(EV_TRIGGER, 1'b0);   // ignored during siren
        send_event(EV_TICK, 1'b1);      // siren ends, jumper fitted: wait
        send_event(EV_TRIGGER, 1'b1);   // ignored during wait
        send_event(EV_TICK, 1'b0);
        send_event(EV_TICK, 1'b0);      // re-armed
        alerts_used = 1;

        // Siren count lowered to zero mid-phase: the counter has to wrap right round.
        settle();
        pre = $urandom_range(1, 8);
        rea = $urandom_range(1, 8);
        program_alarm($urandom_range(1, 255), pre, 5, rea, 8'($urandom_range(2, 7)));
        send_event(EV_TRIGGER, 1'($urandom_range(0, 1)));
        send_ticks(pre + 3, 0);
        settle();
        pending_writes.push_back('{CFG_SIREN, 8'd0});
        flush_register_writes();
        // Receiver holds off while the sender keeps offering.
        hold_asked <= hold_asked + 1;
        gapless_items = 40;
        send_ticks(253, 253);
        send_ticks(rea, 0);
        alerts_used = 2;

        // Further rounds until the alert count is spent; the last one latches.
        while (alerts_used <= 7) begin
            settle();
            if (alerts_used == 2) begin
                pre = 1;
                sir = 1;
                rea = 1;
            end else begin
                pre = $urandom_range(1, 10);
                sir = $urandom_range(1, 10);
                rea = $urandom_range(1, 10);
            end
            limit = (alerts_used == 7) ? 8'hF8 : $urandom_range(alerts_used + 1, 7);
            program_alarm($urandom_range(1, 255), pre, sir, rea, 8'(limit));
            run_alert_cycle(pre, sir, rea, alerts_used == 7);
            alerts_used++;
        end

        // Latched: nothing moves it any more, whatever the registers say.
        settle();
        program_alarm(255, 0, 255, 255, 8'd3);
        repeat (20) send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        settle();

        $display("Sent %0d events and %0d register writes; %0d result words checked.",
                 events_sent, writes_done, words_checked);
        $display("Covered seven re-armed alert rounds, a full counter wrap in the siren phase "
                 , "and the latched final phase.");
        if (fail_count == 0) begin
            $display("intrusion_alarm_sequencer_test passed");
        end else begin
            $display("intrusion_alarm_sequencer_test failed");
        end
        $finish;
    end

endmodule
